/* sv/hcke_pkg.sv */
// shared types and key codes for the hex calculator key engine
`default_nettype none
package hcke_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned KEY_W     = 8;
   localparam int unsigned DIGIT_W   = 4;
   localparam int unsigned MD_STEPS  = DATA_W;
   localparam int unsigned MD_CNT_W  = $clog2(MD_STEPS);

   localparam logic [KEY_W-1:0] KEY_BACK   = 8'h08;
   localparam logic [KEY_W-1:0] KEY_ENTER  = 8'h0D;
   localparam logic [KEY_W-1:0] KEY_ESC    = 8'h1B;
   localparam logic [KEY_W-1:0] KEY_ZERO   = 8'h30;
   localparam logic [KEY_W-1:0] KEY_NINE   = 8'h39;
   localparam logic [KEY_W-1:0] KEY_UP_A   = 8'h41;
   localparam logic [KEY_W-1:0] KEY_UP_F   = 8'h46;
   localparam logic [KEY_W-1:0] KEY_LO_A   = 8'h61;
   localparam logic [KEY_W-1:0] KEY_LO_Z   = 8'h7A;
   localparam logic [KEY_W-1:0] CASE_DELTA = 8'h20;
   localparam logic [KEY_W-1:0] ALPHA_BASE = KEY_UP_A - 8'd10;

   localparam logic [KEY_W-1:0] OP_EQ  = 8'h3D;
   localparam logic [KEY_W-1:0] OP_ADD = 8'h2B;
   localparam logic [KEY_W-1:0] OP_SUB = 8'h2D;
   localparam logic [KEY_W-1:0] OP_MUL = 8'h2A;
   localparam logic [KEY_W-1:0] OP_AND = 8'h26;
   localparam logic [KEY_W-1:0] OP_OR  = 8'h7C;
   localparam logic [KEY_W-1:0] OP_XOR = 8'h5E;
   localparam logic [KEY_W-1:0] OP_SHL = 8'h3C;
   localparam logic [KEY_W-1:0] OP_SHR = 8'h3E;
   localparam logic [KEY_W-1:0] OP_DIV = 8'h2F;
   localparam logic [KEY_W-1:0] OP_MOD = 8'h25;

   localparam logic [DATA_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] ENTRY_LIMIT = 32'h0FFF_FFFF;

   typedef enum logic [1:0] {
      KIND_BACK  = 2'd0,
      KIND_ESC   = 2'd1,
      KIND_DIGIT = 2'd2,
      KIND_OPER  = 2'd3
   } key_kind_type;

   typedef struct packed {
      key_kind_type        kind;
      logic [DIGIT_W-1:0]  digit;
      logic [KEY_W-1:0]    code;
   } key_info_type;

   typedef enum logic [1:0] {
      MD_MUL = 2'd0,
      MD_DIV = 2'd1,
      MD_MOD = 2'd2
   } md_mode_type;

   typedef struct packed {
      logic        start;
      md_mode_type mode;
   } md_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md_stat_type;

endpackage
`default_nettype wire

/* sv/hcke_keydec.sv */
// key folding and classification of one key code
`default_nettype none
module hcke_keydec (
   input  wire logic [hcke_pkg::KEY_W-1:0] key_code,
   output hcke_pkg::key_info_type          key_info
);
   import hcke_pkg::*;

   logic [KEY_W-1:0] folded;
   logic [KEY_W-1:0] digit_full;

   always_comb begin
      if (key_code == KEY_ENTER) begin
         folded = OP_EQ;
      end else if (key_code >= KEY_LO_A && key_code <= KEY_LO_Z) begin
         folded = key_code - CASE_DELTA;
      end else begin
         folded = key_code;
      end

      digit_full = (folded <= KEY_NINE) ? folded - KEY_ZERO : folded - ALPHA_BASE;

      key_info.code  = folded;
      key_info.digit = digit_full[DIGIT_W-1:0];
      if (folded == KEY_BACK) begin
         key_info.kind = KIND_BACK;
      end else if (folded == KEY_ESC) begin
         key_info.kind = KIND_ESC;
      end else if ((folded >= KEY_ZERO && folded <= KEY_NINE) ||
                   (folded >= KEY_UP_A && folded <= KEY_UP_F)) begin
         key_info.kind = KIND_DIGIT;
      end else begin
         key_info.kind = KIND_OPER;
      end
   end

endmodule
`default_nettype wire

/* sv/hcke_muldiv.sv */
// iterative shift-add multiplier and restoring divider, one bit per cycle
`default_nettype none
module hcke_muldiv (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire hcke_pkg::md_ctrl_type       md_ctrl,
   input  wire logic [hcke_pkg::DATA_W-1:0] opa,
   input  wire logic [hcke_pkg::DATA_W-1:0] opb,
   output hcke_pkg::md_stat_type            md_stat,
   output logic      [hcke_pkg::DATA_W-1:0] md_result
);
   import hcke_pkg::*;

   logic [DATA_W-1:0]   acc_ff, acc_in;
   logic [DATA_W-1:0]   sa_ff, sa_in;
   logic [DATA_W-1:0]   sb_ff, sb_in;
   logic [MD_CNT_W-1:0] cnt_ff, cnt_in;
   md_mode_type         mode_ff, mode_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DATA_W+1:0]   trial;
   logic [DATA_W:0]     rem_shift;

   always_comb begin
      acc_in    = acc_ff;
      sa_in     = sa_ff;
      sb_in     = sb_ff;
      cnt_in    = cnt_ff;
      mode_in   = mode_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      // partial remainder can reach bit 31, so the shifted value needs 33 bits
      rem_shift = {acc_ff, sa_ff[DATA_W-1]};
      trial     = {1'b0, rem_shift} - {2'b00, sb_ff};

      if (md_ctrl.start && !busy_ff) begin
         acc_in  = '0;
         sa_in   = opa;
         sb_in   = opb;
         cnt_in  = '0;
         mode_in = md_ctrl.mode;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mode_ff == MD_MUL) begin
            if (sb_ff[0]) begin
               acc_in = acc_ff + sa_ff;
            end
            sa_in = {sa_ff[DATA_W-2:0], 1'b0};
            sb_in = {1'b0, sb_ff[DATA_W-1:1]};
         end else begin
            // restoring step: keep the difference when it does not borrow
            if (!trial[DATA_W+1]) begin
               acc_in = trial[DATA_W-1:0];
            end else begin
               acc_in = rem_shift[DATA_W-1:0];
            end
            sa_in = {sa_ff[DATA_W-2:0], ~trial[DATA_W+1]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MD_CNT_W'(MD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      sa_ff   <= sa_in;
      sb_ff   <= sb_in;
      cnt_ff  <= cnt_in;
      mode_ff <= mode_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign md_stat.busy = busy_ff;
   assign md_stat.done = done_ff;
   assign md_result    = (mode_ff == MD_DIV) ? sa_ff : acc_ff;

endmodule
`default_nettype wire

/* sv/hex_calculator_key_engine.sv */
// top level: key sequencer, register state and simple alu around the shared mul/div unit
// digits, backspace, clear and simple operators: result valid in the cycle after the transaction
// multiply, divide and modulo by a nonzero entry: the mul/div unit iterates, then the result is written back
// one key at a time: req_ready returns the cycle after the result is taken, so no new key is
// accepted while the previous one is still being computed or waits for its result to be taken
// synchronous reset: entry and first operand 0, pending operator '=', new-number flag set
`default_nettype none
module hex_calculator_key_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [hcke_pkg::KEY_W-1:0]        req_key_code,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [hcke_pkg::DATA_W-1:0]       rsp_display_value,
   output logic                                   rsp_overflow_beep
);
   import hcke_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WAIT = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] entry_ff, entry_in;
   logic [DATA_W-1:0] first_ff, first_in;
   logic [KEY_W-1:0]  pend_ff, pend_in;
   logic              newnum_ff, newnum_in;
   logic              beep_ff, beep_in;
   logic              rsp_valid_ff, rsp_valid_in;

   key_info_type      key_info;
   md_ctrl_type       md_ctrl;
   md_stat_type       md_stat;
   logic [DATA_W-1:0] md_result;
   logic [DATA_W-1:0] alu_out;
   logic [DATA_W-1:0] digit_base;
   logic              long_op;
   logic              accept;

   hcke_keydec u_keydec (
      .key_code (req_key_code),
      .key_info (key_info)
   );

   hcke_muldiv u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .md_ctrl   (md_ctrl),
      .opa       (first_ff),
      .opb       (entry_ff),
      .md_stat   (md_stat),
      .md_result (md_result)
   );

   // combinational operators; divide by zero lands here too
   always_comb begin
      unique case (pend_ff)
         OP_EQ:   alu_out = entry_ff;
         OP_ADD:  alu_out = first_ff + entry_ff;
         OP_SUB:  alu_out = first_ff - entry_ff;
         OP_AND:  alu_out = first_ff & entry_ff;
         OP_OR:   alu_out = first_ff | entry_ff;
         OP_XOR:  alu_out = first_ff ^ entry_ff;
         OP_SHL:  alu_out = (|entry_ff[DATA_W-1:5]) ? '0 : first_ff << entry_ff[4:0];
         OP_SHR:  alu_out = (|entry_ff[DATA_W-1:5]) ? '0 : first_ff >> entry_ff[4:0];
         OP_DIV:  alu_out = ALL_ONES;
         OP_MOD:  alu_out = ALL_ONES;
         default: alu_out = '0;
      endcase
   end

   assign long_op = (pend_ff == OP_MUL) ||
                    (((pend_ff == OP_DIV) || (pend_ff == OP_MOD)) && (entry_ff != '0));
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign digit_base = newnum_ff ? '0 : entry_ff;

   always_comb begin
      state_in     = state_ff;
      entry_in     = entry_ff;
      first_in     = first_ff;
      pend_in      = pend_ff;
      newnum_in    = newnum_ff;
      beep_in      = beep_ff;
      rsp_valid_in = rsp_valid_ff;
      md_ctrl.start = 1'b0;
      md_ctrl.mode  = (pend_ff == OP_MUL) ? MD_MUL :
                      (pend_ff == OP_DIV) ? MD_DIV : MD_MOD;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               beep_in      = 1'b0;
               state_in     = ST_RESP;
               rsp_valid_in = 1'b1;
               unique case (key_info.kind)
                  KIND_BACK: entry_in = {4'h0, entry_ff[DATA_W-1:4]};
                  KIND_ESC:  entry_in = '0;
                  KIND_DIGIT: begin
                     if (newnum_ff) begin
                        first_in = entry_ff;
                     end
                     newnum_in = 1'b0;
                     if (digit_base <= ENTRY_LIMIT) begin
                        entry_in = {digit_base[DATA_W-5:0], key_info.digit};
                     end else begin
                        entry_in = digit_base;
                        beep_in  = 1'b1;
                     end
                  end
                  KIND_OPER: begin
                     if (!newnum_ff) begin
                        if (long_op) begin
                           md_ctrl.start = 1'b1;
                           state_in      = ST_WAIT;
                           rsp_valid_in  = 1'b0;
                        end else begin
                           entry_in = alu_out;
                        end
                     end
                     newnum_in = 1'b1;
                     pend_in   = key_info.code;
                  end
                  default: entry_in = entry_ff;
               endcase
            end
         end
         ST_WAIT: begin
            if (md_stat.done) begin
               entry_in     = md_result;
               rsp_valid_in = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entry_ff     <= '0;
         first_ff     <= '0;
         pend_ff      <= OP_EQ;
         newnum_ff    <= 1'b1;
         beep_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entry_ff     <= entry_in;
         first_ff     <= first_in;
         pend_ff      <= pend_in;
         newnum_ff    <= newnum_in;
         beep_ff      <= beep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_display_value = entry_ff;
   assign rsp_overflow_beep = beep_ff;

endmodule
`default_nettype wire

/* tb/hex_calculator_key_engine_test.sv */
// self-checking testbench for the hex calculator key engine: directed key table plus random keys
module hex_calculator_key_engine_test;
   import hcke_pkg::*;

   localparam int RESET_CYCLES   = 5;
   localparam int TOTAL_KEYS     = 1150;
   localparam int PAUSE_EVERY    = 300;
   localparam int HOLD_AT        = 600;
   localparam int RSP_HOLD       = 300;
   localparam int DRAIN_CYCLES   = 60;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic [KEY_W-1:0] KEY_UNKNOWN = 8'hFF;

   localparam int OPER_N = 12;
   localparam logic [KEY_W-1:0] OPER_KEYS [OPER_N] = '{
      OP_EQ, OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR,
      OP_XOR, OP_SHL, OP_SHR, OP_DIV, OP_MOD, KEY_ENTER
   };

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              beep;
   } key_result_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic              known;
      logic [DATA_W-1:0] value;
      logic              beep;
   } key_row_type;

   // rows with known set carry a typed result, the rest go through the predictor
   localparam int DIRECTED_ROWS = 36;
   localparam key_row_type DIRECTED_KEYS [DIRECTED_ROWS] = '{
      '{"F",         1'b1, 32'h0000_000F, 1'b0},
      '{"e",         1'b0, '0,            1'b0},
      '{"D",         1'b0, '0,            1'b0},
      '{"c",         1'b0, '0,            1'b0},
      '{"B",         1'b0, '0,            1'b0},
      '{"a",         1'b0, '0,            1'b0},
      '{"9",         1'b0, '0,            1'b0},
      '{"8",         1'b0, '0,            1'b0},
      '{"7",         1'b1, 32'hFEDC_BA98, 1'b1},
      '{KEY_BACK,    1'b1, 32'h0FED_CBA9, 1'b0},
      '{OP_ADD,      1'b0, '0,            1'b0},
      '{"1",         1'b0, '0,            1'b0},
      '{OP_SUB,      1'b0, '0,            1'b0},
      '{"2",         1'b0, '0,            1'b0},
      '{OP_MUL,      1'b0, '0,            1'b0},
      '{"3",         1'b0, '0,            1'b0},
      '{OP_AND,      1'b0, '0,            1'b0},
      '{"c",         1'b0, '0,            1'b0},
      '{OP_OR,       1'b0, '0,            1'b0},
      '{"6",         1'b0, '0,            1'b0},
      '{OP_XOR,      1'b0, '0,            1'b0},
      '{"7",         1'b0, '0,            1'b0},
      '{OP_SHR,      1'b0, '0,            1'b0},
      '{"1",         1'b0, '0,            1'b0},
      '{OP_DIV,      1'b0, '0,            1'b0},
      '{"0",         1'b0, '0,            1'b0},
      '{OP_MOD,      1'b1, ALL_ONES,      1'b0},
      '{"0",         1'b0, '0,            1'b0},
      '{KEY_ENTER,   1'b1, ALL_ONES,      1'b0},
      '{OP_SHL,      1'b1, ALL_ONES,      1'b0},
      '{"2",         1'b0, '0,            1'b0},
      '{"0",         1'b0, '0,            1'b0},
      '{"z",         1'b1, '0,            1'b0},
      '{"5",         1'b0, '0,            1'b0},
      '{KEY_UNKNOWN, 1'b1, '0,            1'b0},
      '{KEY_ESC,     1'b1, '0,            1'b0}
   };

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [KEY_W-1:0]    req_key_code = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DATA_W-1:0]   rsp_display_value;
   logic                rsp_overflow_beep;

   // calculator state as the predictor sees it
   logic [DATA_W-1:0]   calc_entry = '0;
   logic [DATA_W-1:0]   calc_operand = '0;
   logic [KEY_W-1:0]    calc_op = OP_EQ;
   logic                calc_new_number = 1'b1;

   key_result_type      pending_results[$];
   logic [KEY_W-1:0]    key_q[$];
   int                  error_count = 0;
   int                  idle_cycles = 0;
   int                  hold_requests = 0;
   int                  hold_served = 0;

   hex_calculator_key_engine u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_key_code      (req_key_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_display_value (rsp_display_value),
      .rsp_overflow_beep (rsp_overflow_beep)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic key_result_type predict_key(input logic [KEY_W-1:0] raw_key);
      key_result_type    res;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] rhs;
      key = raw_key;
      res.beep = 1'b0;
      if (key == KEY_ENTER) begin
         key = OP_EQ;
      end else if (key >= KEY_LO_A && key <= KEY_LO_Z) begin
         key = key - CASE_DELTA;
      end
      if (key == KEY_BACK) begin
         calc_entry = calc_entry >> DIGIT_W;
      end else if (key == KEY_ESC) begin
         calc_entry = '0;
      end else if ((key >= KEY_ZERO && key <= KEY_NINE) ||
                   (key >= KEY_UP_A && key <= KEY_UP_F)) begin
         if (calc_new_number) begin
            calc_operand = calc_entry;
            calc_entry = '0;
         end
         calc_new_number = 1'b0;
         if (calc_entry > ENTRY_LIMIT) begin
            res.beep = 1'b1;
         end else begin
            calc_entry = {calc_entry[DATA_W-DIGIT_W-1:0],
                          DIGIT_W'((key <= KEY_NINE) ? key - KEY_ZERO : key - ALPHA_BASE)};
         end
      end else begin
         // an operator only computes when a number was typed since the last one
         if (!calc_new_number) begin
            rhs = calc_entry;
            case (calc_op)
               OP_EQ:   calc_entry = rhs;
               OP_ADD:  calc_entry = calc_operand + rhs;
               OP_SUB:  calc_entry = calc_operand - rhs;
               OP_MUL:  calc_entry = calc_operand * rhs;
               OP_AND:  calc_entry = calc_operand & rhs;
               OP_OR:   calc_entry = calc_operand | rhs;
               OP_XOR:  calc_entry = calc_operand ^ rhs;
               OP_SHL:  calc_entry = (rhs >= DATA_W) ? '0 : calc_operand << rhs;
               OP_SHR:  calc_entry = (rhs >= DATA_W) ? '0 : calc_operand >> rhs;
               OP_DIV:  calc_entry = (rhs == '0) ? ALL_ONES : calc_operand / rhs;
               OP_MOD:  calc_entry = (rhs == '0) ? ALL_ONES : calc_operand % rhs;
               default: calc_entry = '0;
            endcase
         end
         calc_new_number = 1'b1;
         calc_op = key;
      end
      res.value = calc_entry;
      return res;
   endfunction

   // key sender
   initial begin
      key_result_type   res;
      logic [KEY_W-1:0] key;
      logic [3:0]       digit;
      int               roll;
      int               n_digits;
      int               burst_left;

      foreach (DIRECTED_KEYS[i]) key_q.push_back(DIRECTED_KEYS[i].key);
      // mostly numbers followed by an operator, with stray keys mixed in
      while (key_q.size() < TOTAL_KEYS) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            key_q.push_back(KEY_W'($urandom_range(0, 255)));
         end else if (roll < 13) begin
            key_q.push_back(roll[0] ? KEY_BACK : KEY_ESC);
         end else begin
            n_digits = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                     : $urandom_range(4, 10);
            repeat (n_digits) begin
               digit = 4'($urandom_range(0, 15));
               if (digit < 10) begin
                  key = KEY_ZERO + digit;
               end else begin
                  key = ALPHA_BASE + digit;
                  if ($urandom_range(0, 1) == 1) key = key + CASE_DELTA;
               end
               key_q.push_back(key);
            end
            if ($urandom_range(0, 19) == 0) begin
               key_q.push_back(KEY_W'($urandom_range(0, 255)));
            end else begin
               key_q.push_back(OPER_KEYS[$urandom_range(0, OPER_N - 1)]);
            end
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 20);

      for (int idx = 0; idx < key_q.size(); idx++) begin
         if (idx == HOLD_AT) begin
            hold_requests++;
            burst_left = 40;
         end
         req_valid <= 1'b1;
         req_key_code <= key_q[idx];
         @(posedge clock);
         while (!req_ready) @(posedge clock);

         res = predict_key(key_q[idx]);
         if (idx < DIRECTED_ROWS && DIRECTED_KEYS[idx].known) begin
            res.value = DIRECTED_KEYS[idx].value;
            res.beep = DIRECTED_KEYS[idx].beep;
         end
         pending_results.push_back(res);

         burst_left--;
         if (idx % PAUSE_EVERY == PAUSE_EVERY - 1) begin
            // let the engine drain completely before the next transaction
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_results.size() != 0);
         end else if (burst_left == 0) begin
            req_valid <= 1'b0;
            roll = $urandom_range(0, 99);
            repeat ((roll < 70) ? $urandom_range(1, 4) : $urandom_range(5, 45)) @(posedge clock);
            burst_left = $urandom_range(1, 20);
         end
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // result receiver: segments of differing stall patterns, plus one long hold-off
   initial begin
      int mode;
      int seg_len;
      wait (reset == 1'b0);
      forever begin
         if (hold_requests != hold_served) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD) @(posedge clock);
            hold_served++;
         end else begin
            mode = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 150);
            for (int phase = 0; phase < seg_len; phase++) begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= ($urandom_range(0, 1) == 1);
                  2: rsp_ready <= (phase % 3 == 0);
                  default: rsp_ready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      key_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: display %h beep %b",
                     $time, rsp_display_value, rsp_overflow_beep);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_display_value !== want.value) begin
               $display("%0t: display_value mismatch: expected %h actual %h",
                        $time, want.value, rsp_display_value);
               error_count++;
            end
            if (rsp_overflow_beep !== want.beep) begin
               $display("%0t: overflow_beep mismatch: expected %b actual %b",
                        $time, want.beep, rsp_overflow_beep);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
